>>> rtl/date_time_normalizer_macros.svh
// Assertion macros for the date/time normalizer checker.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef DATE_TIME_NORMALIZER_MACROS_SVH
`define DATE_TIME_NORMALIZER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DTN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define DTN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/dtn_pkg.sv
// Shared types, constants and helper functions for the date/time normalizer.
// No dependencies.
package dtn_pkg;

  // Field widths
  localparam int YEAR_W      = 14;
  localparam int MONTH_IN_W  = 8;
  localparam int DAY_IN_W    = 16;
  localparam int HOUR_IN_W   = 16;
  localparam int MIN_IN_W    = 16;
  localparam int MONTH_OUT_W = 4;
  localparam int DAY_OUT_W   = 5;
  localparam int HOUR_OUT_W  = 5;
  localparam int MIN_OUT_W   = 6;

  // Internal widths
  localparam int YEAR_INT_W = 15;  // year can pass 16383 before saturation
  localparam int DAY_INT_W  = 17;  // day plus carried days
  localparam int HOUR_INT_W = 17;  // hour plus carried hours
  localparam int REM_W      = 9;   // remainder below 400
  localparam int LEN_W      = 5;

  // Reciprocal division: q = (x * ceil(2^s / d)) >> s, exact over each operand range
  localparam int YR_PROD_W  = 21;  // (year >> 4) * 1311, s = 15, gives year / 400
  localparam int MIN_PROD_W = 32;  // minute * 34953, s = 21, gives minute / 60
  localparam int HR_PROD_W  = 28;  // (hour >> 3) * 10923, s = 15, gives hour / 24
  localparam int YR_Q_W     = 6;
  localparam int MIN_Q_W    = 11;
  localparam int HR_Q_W     = 13;

  localparam logic [10:0] RCP_25 = 11'd1311;
  localparam logic [15:0] RCP_60 = 16'd34953;
  localparam logic [13:0] RCP_3  = 14'd10923;

  localparam logic [YEAR_W-1:0]     YEARS_400       = YEAR_W'(400);
  localparam logic [MIN_IN_W-1:0]   MINS_PER_HOUR   = MIN_IN_W'(60);
  localparam logic [HOUR_INT_W-1:0] HOURS_PER_DAY   = HOUR_INT_W'(24);
  localparam logic [YEAR_INT_W-1:0] YEAR_MAX        = YEAR_INT_W'(16383);
  localparam logic [MONTH_IN_W-1:0] MONTHS_PER_YEAR = MONTH_IN_W'(12);
  localparam logic [DAY_INT_W-1:0]  DAYS_MAX        = DAY_INT_W'(31);
  localparam logic [REM_W-1:0]      Y400_LAST       = REM_W'(399);
  localparam logic [REM_W-1:0]      Y400_C1         = REM_W'(100);
  localparam logic [REM_W-1:0]      Y400_C2         = REM_W'(200);
  localparam logic [REM_W-1:0]      Y400_C3         = REM_W'(300);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MIN_DIV,
    S_HR_DIV,
    S_MWRAP,
    S_DAY,
    S_FIX,
    S_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic min_div;
    logic hr_div;
    logic wrap_step;
    logic day_step;
    logic fix_step;
    logic out_load;
  } dtn_cmd_t;

  typedef struct packed {
    logic in_month_zero;
    logic month_gt12;
    logic day_gt31;
  } dtn_stat_t;

  // y400 is year mod 400; low bits of year give mod 4 since 4 divides 400
  function automatic logic is_leap(input logic [REM_W-1:0] y400, input logic [1:0] y_lo);
    return (y400 == '0) ||
           ((y_lo == 2'b00) && (y400 != Y400_C1) && (y400 != Y400_C2) && (y400 != Y400_C3));
  endfunction

  function automatic logic [LEN_W-1:0] month_len(input logic [MONTH_IN_W-1:0] m,
                                                 input logic leap);
    logic [LEN_W-1:0] len;
    unique case (m)
      MONTH_IN_W'(2):  len = leap ? LEN_W'(29) : LEN_W'(28);
      MONTH_IN_W'(4),
      MONTH_IN_W'(6),
      MONTH_IN_W'(9),
      MONTH_IN_W'(11): len = LEN_W'(30);
      default:         len = LEN_W'(31);
    endcase
    return len;
  endfunction

endpackage

>>> rtl/dtn_if.sv
// Valid/ready channel interfaces for the date/time normalizer input and output.
// Depends on dtn_pkg for field widths.
interface dtn_in_if import dtn_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [YEAR_W-1:0]     in_year;
  logic [MONTH_IN_W-1:0] in_month;
  logic [DAY_IN_W-1:0]   in_day;
  logic [HOUR_IN_W-1:0]  in_hour;
  logic [MIN_IN_W-1:0]   in_minute;

  modport source (output valid, in_year, in_month, in_day, in_hour, in_minute,
                  input ready);
  modport sink   (input valid, in_year, in_month, in_day, in_hour, in_minute,
                  output ready);
endinterface

interface dtn_out_if import dtn_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [YEAR_W-1:0]      out_year;
  logic [MONTH_OUT_W-1:0] out_month;
  logic [DAY_OUT_W-1:0]   out_day;
  logic [HOUR_OUT_W-1:0]  out_hour;
  logic [MIN_OUT_W-1:0]   out_minute;
  logic                   bad_month;

  modport source (output valid, out_year, out_month, out_day, out_hour, out_minute,
                  bad_month, input ready);
  modport sink   (input valid, out_year, out_month, out_day, out_hour, out_minute,
                  bad_month, output ready);
endinterface

>>> rtl/dtn_dpath.sv
// Datapath: field registers, reciprocal-multiply carries, month stepping, result register.
// Depends on dtn_pkg; driven by dtn_ctrl through dtn_cmd_t.
module dtn_dpath import dtn_pkg::*; (
  input  logic                   clk,
  input  dtn_cmd_t               cmd,
  output dtn_stat_t              stat,
  input  logic [YEAR_W-1:0]      in_year,
  input  logic [MONTH_IN_W-1:0]  in_month,
  input  logic [DAY_IN_W-1:0]    in_day,
  input  logic [HOUR_IN_W-1:0]   in_hour,
  input  logic [MIN_IN_W-1:0]    in_minute,
  output logic [YEAR_W-1:0]      out_year,
  output logic [MONTH_OUT_W-1:0] out_month,
  output logic [DAY_OUT_W-1:0]   out_day,
  output logic [HOUR_OUT_W-1:0]  out_hour,
  output logic [MIN_OUT_W-1:0]   out_minute,
  output logic                   bad_month
);

  logic [YEAR_INT_W-1:0] year;
  logic [REM_W-1:0]      y400;
  logic [MONTH_IN_W-1:0] month;
  logic [DAY_INT_W-1:0]  day;
  logic [HOUR_INT_W-1:0] hour;
  logic [MIN_IN_W-1:0]   minute;
  logic                  bad;

  logic [YR_PROD_W-1:0]  yr_prod;
  logic [YR_Q_W-1:0]     yr_q;
  logic [YEAR_W-1:0]     yr_rem;
  logic [MIN_PROD_W-1:0] min_prod;
  logic [MIN_Q_W-1:0]    min_q;
  logic [MIN_IN_W-1:0]   min_rem;
  logic [HR_PROD_W-1:0]  hr_prod;
  logic [HR_Q_W-1:0]     hr_q;
  logic [HOUR_INT_W-1:0] hr_rem;
  logic                  leap;
  logic [LEN_W-1:0]      len;
  logic [REM_W-1:0]      y400_inc;

  // year / 400 = (year / 16) / 25; year still holds the input value here
  assign yr_prod  = YR_PROD_W'(year[YEAR_W-1:4]) * YR_PROD_W'(RCP_25);
  assign yr_q     = yr_prod[YR_PROD_W-1 -: YR_Q_W];
  assign yr_rem   = year[YEAR_W-1:0] - YEAR_W'(yr_q) * YEARS_400;

  // minute / 60 in one multiply
  assign min_prod = MIN_PROD_W'(minute) * MIN_PROD_W'(RCP_60);
  assign min_q    = min_prod[MIN_PROD_W-1 -: MIN_Q_W];
  assign min_rem  = minute - MIN_IN_W'(min_q) * MINS_PER_HOUR;

  // hour / 24 = (hour / 8) / 3, hour already includes the minute carry
  assign hr_prod  = HR_PROD_W'(hour[HOUR_INT_W-1:3]) * HR_PROD_W'(RCP_3);
  assign hr_q     = hr_prod[HR_PROD_W-1 -: HR_Q_W];
  assign hr_rem   = hour - HOUR_INT_W'(hr_q) * HOURS_PER_DAY;

  assign leap     = is_leap(y400, year[1:0]);
  assign len      = month_len(month, leap);
  assign y400_inc = (y400 == Y400_LAST) ? '0 : y400 + 1'b1;

  assign stat.in_month_zero = (in_month == '0);
  assign stat.month_gt12    = (month > MONTHS_PER_YEAR);
  assign stat.day_gt31      = (day > DAYS_MAX);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      year   <= YEAR_INT_W'(in_year);
      month  <= in_month;
      day    <= DAY_INT_W'(in_day);
      hour   <= HOUR_INT_W'(in_hour);
      minute <= in_minute;
      bad    <= (in_month == '0);
    end
    if (cmd.min_div) begin
      y400   <= yr_rem[REM_W-1:0];
      minute <= min_rem;
      hour   <= hour + HOUR_INT_W'(min_q);
    end
    if (cmd.hr_div) begin
      hour <= hr_rem;
      day  <= day + DAY_INT_W'(hr_q);
    end
    if (cmd.wrap_step) begin
      month <= month - MONTHS_PER_YEAR;
      year  <= year + 1'b1;
      y400  <= y400_inc;
    end
    if (cmd.day_step) begin
      day <= day - DAY_INT_W'(len);
      if (month == MONTHS_PER_YEAR) begin
        month <= MONTH_IN_W'(1);
        year  <= year + 1'b1;
        y400  <= y400_inc;
      end else begin
        month <= month + 1'b1;
      end
    end
    if (cmd.fix_step) begin
      if (day > DAY_INT_W'(len)) begin
        day   <= day - DAY_INT_W'(len);
        month <= month + 1'b1;
      end
    end
    if (cmd.out_load) begin
      if (bad) begin
        out_year   <= '0;
        out_month  <= '0;
        out_day    <= '0;
        out_hour   <= '0;
        out_minute <= '0;
      end else begin
        out_year   <= (year > YEAR_MAX) ? YEAR_MAX[YEAR_W-1:0] : year[YEAR_W-1:0];
        out_month  <= month[MONTH_OUT_W-1:0];
        out_day    <= day[DAY_OUT_W-1:0];
        out_hour   <= hour[HOUR_OUT_W-1:0];
        out_minute <= minute[MIN_OUT_W-1:0];
      end
      bad_month <= bad;
    end
  end

endmodule

>>> rtl/dtn_ctrl.sv
// Controller: sequences the carry steps and the month loops, owns both handshakes.
// Depends on dtn_pkg; drives dtn_dpath through dtn_cmd_t.
module dtn_ctrl import dtn_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dtn_stat_t stat,
  output dtn_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   out_busy;

  assign out_busy = out_valid && !out_ready;
  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = stat.in_month_zero ? S_OUT : S_MIN_DIV;
        end
      end
      S_MIN_DIV: state_next = S_HR_DIV;
      S_HR_DIV:  state_next = S_MWRAP;
      S_MWRAP:   if (!stat.month_gt12) state_next = S_DAY;
      S_DAY:     if (!stat.day_gt31) state_next = S_FIX;
      S_FIX:     state_next = S_OUT;
      S_OUT:     if (!out_busy) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:    cmd.accept = in_valid;
      S_MIN_DIV: cmd.min_div = 1'b1;
      S_HR_DIV:  cmd.hr_div = 1'b1;
      S_MWRAP:   cmd.wrap_step = stat.month_gt12;
      S_DAY:     cmd.day_step = stat.day_gt31;
      S_FIX:     cmd.fix_step = 1'b1;
      S_OUT:     cmd.out_load = !out_busy;
      default:   cmd.accept = 1'b0;
    endcase
  end

endmodule

>>> rtl/date_time_normalizer.sv
// Gregorian date/time normalizer. One transaction in gives one transaction out. Minutes carry
// into hours (mod 60), hours into days (mod 24), months above 12 wrap into years, then the
// day is reduced one month at a time (30/31 days, February 28/29 by the 400/4/100 rule) until
// it fits. A month of 0 sets bad_month with every other field zero; a day of 0 with no carry
// stays 0. out_year saturates at 16383. Items are handled one at a time: the input is ready
// only while the controller is idle. The time from input transaction to output valid grows
// with W, the number of 12-month wraps ((in_month - 1) / 12, at most 21), and with D, the
// number of months stepped off the day (up to about 2245 for the largest day/hour/minute
// inputs); a zero month goes straight from idle to the output state. Two carry steps
// (minute by 60 together with year mod 400, then hour by 24) use constant reciprocal
// multiplies; the month-stepping loop, one month per cycle, dominates large inputs. A finished
// result sits in an output register, and the next input transaction is taken while it waits;
// if that next result is done before the first is taken, it holds in the controller.
// Depends on dtn_pkg, dtn_if, dtn_ctrl and dtn_dpath.
module date_time_normalizer import dtn_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  dtn_in_if.sink     in_ch,
  dtn_out_if.source  out_ch
);

  dtn_cmd_t  cmd;   // controller -> datapath
  dtn_stat_t stat;  // datapath -> controller

  // control: state sequencing plus both valid/ready handshakes
  dtn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic and field storage; result register feeds the output channel directly
  dtn_dpath u_dpath (
    .clk        (clk),
    .cmd        (cmd),
    .stat       (stat),
    .in_year    (in_ch.in_year),
    .in_month   (in_ch.in_month),
    .in_day     (in_ch.in_day),
    .in_hour    (in_ch.in_hour),
    .in_minute  (in_ch.in_minute),
    .out_year   (out_ch.out_year),
    .out_month  (out_ch.out_month),
    .out_day    (out_ch.out_day),
    .out_hour   (out_ch.out_hour),
    .out_minute (out_ch.out_minute),
    .bad_month  (out_ch.bad_month)
  );

endmodule

>>> rtl/dtn_checker.sv
// Port-level checks for date_time_normalizer, attached by bind.
// Depends on date_time_normalizer_macros.svh and dtn_pkg.
`include "date_time_normalizer_macros.svh"

module dtn_checker import dtn_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [YEAR_W-1:0]      out_year,
  input logic [MONTH_OUT_W-1:0] out_month,
  input logic [DAY_OUT_W-1:0]   out_day,
  input logic [HOUR_OUT_W-1:0]  out_hour,
  input logic [MIN_OUT_W-1:0]   out_minute,
  input logic                   bad_month
);

  logic [YEAR_W+MONTH_OUT_W+DAY_OUT_W+HOUR_OUT_W+MIN_OUT_W-1:0] out_fields;
  logic [YEAR_W+MONTH_OUT_W+DAY_OUT_W+HOUR_OUT_W+MIN_OUT_W:0]   out_data;
  logic out_stall;
  logic good_range;

  assign out_fields = {out_year, out_month, out_day, out_hour, out_minute};
  assign out_data   = {out_fields, bad_month};
  assign out_stall  = out_valid && !out_ready;
  assign good_range = (out_minute < MIN_OUT_W'(60)) && (out_hour < HOUR_OUT_W'(24)) &&
                      (out_month != '0) && (out_month <= MONTH_OUT_W'(12));

  // a stalled result keeps valid and payload
  `DTN_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_data), "stalled output changed")

  // an invalid month yields an all-zero result
  `DTN_ASSERT_NOW(a_bad_zero, out_valid && bad_month, out_fields == '0, "bad result not zero")

  // a good result is in range
  `DTN_ASSERT_NOW(a_good_range, out_valid && !bad_month, good_range, "field out of range")

  // no result can appear the cycle right after an input transaction
  `DTN_ASSERT_NEXT(a_no_instant, in_valid && in_ready, !$rose(out_valid), "result too early")

endmodule

bind date_time_normalizer dtn_checker u_dtn_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_year   (out_ch.out_year),
  .out_month  (out_ch.out_month),
  .out_day    (out_ch.out_day),
  .out_hour   (out_ch.out_hour),
  .out_minute (out_ch.out_minute),
  .bad_month  (out_ch.bad_month)
);

>>> tb/tb_date_time_normalizer.sv
`timescale 1ns / 1ps
// Self-checking testbench for the date/time normalizer: directed calendar corners, then random
// dates under three valid/ready idle patterns. Depends on dtn_pkg, dtn_if and date_time_normalizer.
module tb_date_time_normalizer import dtn_pkg::*;;

  // One input transaction, at the widths of the input channel.
  typedef struct packed {
    logic [YEAR_W-1:0]     year;
    logic [MONTH_IN_W-1:0] month;
    logic [DAY_IN_W-1:0]   day;
    logic [HOUR_IN_W-1:0]  hour;
    logic [MIN_IN_W-1:0]   minute;
  } date_in_t;

  // One output transaction, at the widths of the output channel.
  typedef struct packed {
    logic [YEAR_W-1:0]      year;
    logic [MONTH_OUT_W-1:0] month;
    logic [DAY_OUT_W-1:0]   day;
    logic [HOUR_OUT_W-1:0]  hour;
    logic [MIN_OUT_W-1:0]   minute;
    logic                   bad_month;
  } date_out_t;

  localparam int DRAIN_CYCLES = 2500;  // a bit above the worst-case latency of the block

  logic clk;
  logic rst;

  dtn_in_if  in_ch ();
  dtn_out_if out_ch ();

  date_time_normalizer dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  date_out_t   pending_dates[$];  // normalized dates still owed by the block
  int unsigned mismatch_count;
  int unsigned tx_idle_pct;       // chance per cycle that the sender holds off
  int unsigned rx_idle_pct;       // chance per cycle that the receiver stalls

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------

  // Length of month m of year y; February follows the 400/4/100 leap rule.
  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    bit leap;
    leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    case (m)
      2:             return leap ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic date_out_t normalize_date(date_in_t d);
    date_out_t   r;
    int unsigned yr, mon, dy, hr, mn, len;
    r = '0;
    // A zero month is flagged and every other field reads zero.
    if (d.month == '0) begin
      r.bad_month = 1'b1;
      return r;
    end
    yr  = d.year;
    mon = d.month;
    dy  = d.day;
    hr  = d.hour;
    mn  = d.minute;
    // Minutes into hours, hours into days.
    hr += mn / 60;
    mn  = mn % 60;
    dy += hr / 24;
    hr  = hr % 24;
    // Fold excess months into years before stepping the day.
    while (mon > 12) begin
      mon -= 12;
      yr++;
    end
    // Peel whole months off the day until it is at most 31.
    while (dy > 31) begin
      dy -= days_in_month(mon, yr);
      mon++;
      if (mon > 12) begin
        mon -= 12;
        yr++;
      end
    end
    // One last step for short months; a zero day never gets here as nonzero.
    len = days_in_month(mon, yr);
    if (dy > len) begin
      dy -= len;
      mon++;
    end
    if (yr > YEAR_MAX) yr = YEAR_MAX;
    r.year   = YEAR_W'(yr);
    r.month  = MONTH_OUT_W'(mon);
    r.day    = DAY_OUT_W'(dy);
    r.hour   = HOUR_OUT_W'(hr);
    r.minute = MIN_OUT_W'(mn);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: changes at the falling edge, acceptance seen at the rising edge
  // ---------------------------------------------------------------------------

  // Called at a falling edge, returns at the falling edge after the transaction is taken.
  task automatic send_date(input int unsigned year, input int unsigned month,
                           input int unsigned day, input int unsigned hour,
                           input int unsigned minute);
    date_in_t d;
    d.year   = YEAR_W'(year);
    d.month  = MONTH_IN_W'(month);
    d.day    = DAY_IN_W'(day);
    d.hour   = HOUR_IN_W'(hour);
    d.minute = MIN_IN_W'(minute);
    // Random hold-off cycles with valid low.
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.in_year   <= d.year;
    in_ch.in_month  <= d.month;
    in_ch.in_day    <= d.day;
    in_ch.in_hour   <= d.hour;
    in_ch.in_minute <= d.minute;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_dates.push_back(normalize_date(d));
    // valid stays high here; the next call or end_stimulus decides what it becomes.
    @(negedge clk);
  endtask

  task automatic end_stimulus();
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Receiver back-pressure.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    date_out_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.year      = out_ch.out_year;
      got.month     = out_ch.out_month;
      got.day       = out_ch.out_day;
      got.hour      = out_ch.out_hour;
      got.minute    = out_ch.out_minute;
      got.bad_month = out_ch.bad_month;
      if (pending_dates.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result %0d-%0d-%0d %0d:%0d bad=%0b", $realtime,
                   got.year, got.month, got.day, got.hour, got.minute, got.bad_month);
      end else begin
        want = pending_dates.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"%0t: mismatch exp %0d-%0d-%0d %0d:%0d bad=%0b ",
                      "got %0d-%0d-%0d %0d:%0d bad=%0b"},
                     $realtime, want.year, want.month, want.day, want.hour, want.minute,
                     want.bad_month, got.year, got.month, got.day, got.hour, got.minute,
                     got.bad_month);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Minute and hour carries, including the largest minute and hour alone.
  task automatic test_time_carry();
    send_date(2023, 1, 1, 0, 0);
    send_date(2023, 12, 31, 23, 60);     // minute 60 at 23:00 carries to midnight and crosses into 2024
    send_date(2023, 1, 1, 0, 65535);
    send_date(2023, 1, 1, 65535, 0);
    send_date(2024, 2, 29, 23, 59);
  endtask

  // Months above 12 fold into the year; 30-day months push day 31 forward.
  task automatic test_month_wrap();
    send_date(2023, 13, 1, 0, 0);
    send_date(2023, 255, 15, 12, 30);
    send_date(2023, 6, 31, 0, 0);
    send_date(0, 12, 65535, 0, 0);
  endtask

  // February 29 in ordinary, leap, century and 400-year years.
  task automatic test_leap_rule();
    send_date(2023, 2, 29, 0, 0);
    send_date(1900, 2, 29, 0, 0);
    send_date(2000, 2, 29, 0, 0);
    send_date(2100, 2, 29, 0, 0);
    send_date(2024, 2, 30, 0, 0);
  endtask

  // Day zero passes through unless hours carry a day in.
  task automatic test_zero_day();
    send_date(0, 1, 0, 0, 0);
    send_date(2023, 4, 0, 23, 59);
    send_date(2023, 4, 0, 24, 0);
  endtask

  // Month zero raises bad_month whatever the other fields hold.
  task automatic test_zero_month();
    send_date(0, 0, 0, 0, 0);
    send_date(16383, 0, 65535, 65535, 65535);
  endtask

  // Years past the 14-bit limit saturate, including with every field at its maximum.
  task automatic test_year_saturation();
    send_date(9999, 255, 65535, 65535, 65535);
    send_date(16383, 255, 65535, 65535, 65535);
    send_date(16383, 12, 31, 23, 59);
    send_date(16383, 13, 1, 0, 0);
  endtask

  // Random dates: mostly small day/hour/minute values so the month-stepping loop stays short,
  // with some full-range values, out-of-range months and the odd zero month.
  task automatic test_random_dates(input int unsigned count);
    int unsigned yr, mon, dy, hr, mn, pick;
    repeat (count) begin
      pick = $urandom_range(99);
      yr   = (pick < 15) ? $urandom_range(16383) : $urandom_range(9999);
      pick = $urandom_range(99);
      if (pick < 5)       mon = 0;
      else if (pick < 75) mon = $urandom_range(12, 1);
      else                mon = $urandom_range(255, 13);
      dy = ($urandom_range(99) < 25) ? $urandom_range(65535) : $urandom_range(400);
      hr = ($urandom_range(99) < 25) ? $urandom_range(65535) : $urandom_range(72);
      mn = ($urandom_range(99) < 25) ? $urandom_range(65535) : $urandom_range(150);
      send_date(yr, mon, dy, hr, mn);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.in_year   = '0;
    in_ch.in_month  = '0;
    in_ch.in_day    = '0;
    in_ch.in_hour   = '0;
    in_ch.in_minute = '0;
    out_ch.ready    = 1'b0;
    mismatch_count  = 0;
    tx_idle_pct     = 15;
    rx_idle_pct     = 88;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed corners under sender-light / receiver-heavy idling.
    test_time_carry();
    test_month_wrap();
    test_leap_rule();
    test_zero_day();
    test_zero_month();
    test_year_saturation();
    test_random_dates(72);

    // Swap the idle pattern.
    tx_idle_pct = 88;
    rx_idle_pct = 15;
    test_random_dates(72);

    // Back-to-back transactions, receiver always ready.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_dates(72);
    end_stimulus();

    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: well above the slowest legal run of about 240 transactions.
  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
